FILE: rtl/urh_pkg.sv
// Shared types and codes for the undo/redo history stack.
// Holds request, action and status codes and the result beat layout.
// No dependencies.
package urh_pkg;

	localparam int REQ_W = 3;
	localparam int TGT_W = 5;
	localparam int LIM_W = 5;
	localparam int OUT_HANDLE_W = 32;
	localparam int OUT_POS_W = 4;
	localparam int OUT_CNT_W = 5;

	localparam logic [REQ_W-1:0] REQ_PUSH  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_UNDO  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_REDO  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_SEEK  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd4;
	localparam logic [REQ_W-1:0] REQ_MARK  = 3'd5;
	localparam logic [REQ_W-1:0] REQ_READ  = 3'd6;

	localparam logic [1:0] ACT_NONE   = 2'd0;
	localparam logic [1:0] ACT_APPLY  = 2'd1;
	localparam logic [1:0] ACT_REVERT = 2'd2;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_RANGE = 2'd1;
	localparam logic [1:0] STS_NULL  = 2'd2;

	typedef struct packed {
		logic [1:0]              action;
		logic [OUT_HANDLE_W-1:0] handle;
		logic [OUT_POS_W-1:0]    pos;
		logic                    last;
		logic [1:0]              status;
		logic                    can_undo;
		logic                    can_redo;
		logic [OUT_CNT_W-1:0]    count;
		logic [OUT_CNT_W-1:0]    cursor;
		logic                    is_clean;
	} res_t;

endpackage

FILE: rtl/urh_ram.sv
// History ring storage: one write port and one read port, read data registered.
// Standalone; no package needed.
module urh_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/urh_ctrl.sv
// Request sequencer for the history stack: decodes a request, updates the
// cursor, count, ring base and clean mark, drives the ring RAM and the result
// register. Depends on urh_pkg.
module urh_ctrl
	import urh_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int HANDLE_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [REQ_W-1:0]         req_type,
	input  logic [31:0]              command_handle,
	input  logic [TGT_W-1:0]         target_index,
	input  logic [LIM_W-1:0]         limit,
	output logic                     res_valid,
	input  logic                     res_ready,
	output res_t                     res,
	output logic                     ram_we,
	output logic [$clog2(DEPTH)-1:0] ram_waddr,
	output logic [HANDLE_BITS-1:0]   ram_wdata,
	output logic                     ram_re,
	output logic [$clog2(DEPTH)-1:0] ram_raddr,
	input  logic [HANDLE_BITS-1:0]   ram_rdata
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > TGT_W) ? CW : TGT_W;
	localparam int PW = (AW > OUT_POS_W) ? AW : OUT_POS_W;
	localparam int HW = (HANDLE_BITS > OUT_HANDLE_W) ? HANDLE_BITS : OUT_HANDLE_W;

	typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_RDWAIT} state_t;

	state_t                 state_q;
	logic [REQ_W-1:0]       req_q;
	logic [HANDLE_BITS-1:0] hnd_q;
	logic [TGT_W-1:0]       tgt_q;
	logic [AW-1:0]          base_q;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          cursor_q;
	logic [CW-1:0]          cpos_q;
	logic                   cvalid_q;
	logic [1:0]             pend_act_q;
	logic [AW-1:0]          pend_pos_q;
	logic [CW-1:0]          pend_cur_q;
	logic                   pend_last_q;
	res_t                   out_q;
	logic                   out_valid_q;

	// Reduce a ring sum below twice the depth to a slot number.
	function automatic logic [AW-1:0] wrap(input logic [CW:0] s);
		logic [CW:0] d;
		d = s - (CW+1)'(DEPTH);
		return (s >= (CW+1)'(DEPTH)) ? d[AW-1:0] : s[AW-1:0];
	endfunction

	function automatic res_t mk(input logic [1:0] act, input logic [AW-1:0] pos,
			input logic lst, input logic [1:0] sts, input logic [HANDLE_BITS-1:0] h,
			input logic [CW-1:0] cnt, input logic [CW-1:0] cur,
			input logic [CW-1:0] cp, input logic cv);
		logic [HW-1:0] hw;
		logic [PW-1:0] pw;
		logic [XW-1:0] cnt_x;
		logic [XW-1:0] cur_x;
		res_t r;
		hw = HW'(h);
		pw = PW'(pos);
		cnt_x = XW'(cnt);
		cur_x = XW'(cur);
		r.action   = act;
		r.handle   = hw[OUT_HANDLE_W-1:0];
		r.pos      = pw[OUT_POS_W-1:0];
		r.last     = lst;
		r.status   = sts;
		r.can_undo = (cnt != '0) && (cur != '0);
		r.can_redo = (cnt != '0) && (cur < cnt);
		r.count    = cnt_x[OUT_CNT_W-1:0];
		r.cursor   = cur_x[OUT_CNT_W-1:0];
		r.is_clean = cv && (cp == cur);
		return r;
	endfunction

	logic [HW-1:0] in_hw;
	logic          out_free;
	logic          out_load;

	// Push arithmetic.
	logic [CW-1:0] p_c;
	logic [CW:0]   p_n1;
	logic [XW-1:0] p_lim_x;
	logic [CW-1:0] p_lim;
	logic          p_over;
	logic [CW:0]   p_del;
	logic [CW-1:0] p_count;
	logic [CW-1:0] p_pos;
	logic          p_cv1;
	logic          p_cv;
	logic [CW-1:0] p_cp;
	logic [AW-1:0] p_wslot;
	logic [AW-1:0] p_base;

	// Execution decode.
	logic [XW-1:0] tgt_x;
	logic [XW-1:0] cnt_x;
	logic [XW-1:0] cur_x;
	logic [CW-1:0] cur_dn;
	logic [CW-1:0] cur_up;
	logic [AW-1:0] slot_dn;
	logic [AW-1:0] slot_cur;
	logic [AW-1:0] slot_tgt;
	logic          ex_read;
	logic [AW-1:0] ex_raddr;
	logic [1:0]    ex_pact;
	logic [AW-1:0] ex_ppos;
	logic [CW-1:0] ex_pcur;
	logic          ex_plast;
	logic          ex_push;
	res_t          ex_res;

	assign in_hw    = HW'(command_handle);
	assign out_free = !out_valid_q || res_ready;
	// A beat enters the output register at this edge.
	assign out_load = out_free &&
		(((state_q == ST_EXEC) && !ex_read) || (state_q == ST_RDWAIT));

	always_comb begin
		p_c     = (cursor_q > count_q) ? count_q : cursor_q;
		p_n1    = (CW+1)'(p_c) + (CW+1)'(1);
		p_lim_x = (limit == '0 || XW'(limit) > XW'(DEPTH)) ? XW'(DEPTH) : XW'(limit);
		p_lim   = CW'(p_lim_x);
		p_over  = p_n1 > (CW+1)'(p_lim);
		p_del   = p_over ? (p_n1 - (CW+1)'(p_lim)) : '0;
		p_count = p_over ? p_lim : p_n1[CW-1:0];
		p_pos   = p_count - CW'(1);
		p_cv1   = cvalid_q && !(cpos_q > p_c);
		// Eviction drops the clean mark when it falls off the old end.
		p_cv    = p_cv1 && !((CW+1)'(cpos_q) < p_del);
		p_cp    = p_cv ? (cpos_q - p_del[CW-1:0]) : cpos_q;
		p_wslot = wrap((CW+1)'(base_q) + (CW+1)'(p_c));
		p_base  = wrap((CW+1)'(base_q) + p_del);
	end

	always_comb begin
		tgt_x    = XW'(tgt_q);
		cnt_x    = XW'(count_q);
		cur_x    = XW'(cursor_q);
		cur_dn   = cursor_q - CW'(1);
		cur_up   = cursor_q + CW'(1);
		slot_dn  = wrap((CW+1)'(base_q) + (CW+1)'(cur_dn));
		slot_cur = wrap((CW+1)'(base_q) + (CW+1)'(cursor_q));
		slot_tgt = wrap((CW+1)'(base_q) + (CW+1)'(tgt_x[AW-1:0]));

		ex_read  = 1'b0;
		ex_raddr = slot_cur;
		ex_pact  = ACT_NONE;
		ex_ppos  = cursor_q[AW-1:0];
		ex_pcur  = cursor_q;
		ex_plast = 1'b1;
		ex_push  = 1'b0;
		ex_res   = mk(ACT_NONE, '0, 1'b1, STS_OK, '0, count_q, cursor_q, cpos_q, cvalid_q);

		case (req_q)
			REQ_PUSH: begin
				if (hnd_q == '0) begin
					ex_res = mk(ACT_NONE, '0, 1'b1, STS_NULL, '0,
						count_q, cursor_q, cpos_q, cvalid_q);
				end else begin
					ex_push = 1'b1;
					ex_res  = mk(ACT_APPLY, p_pos[AW-1:0], 1'b1, STS_OK, hnd_q,
						p_count, p_count, p_cp, p_cv);
				end
			end
			REQ_UNDO: begin
				if (cursor_q != '0) begin
					ex_read  = 1'b1;
					ex_raddr = slot_dn;
					ex_pact  = ACT_REVERT;
					ex_ppos  = cur_dn[AW-1:0];
					ex_pcur  = cur_dn;
				end
			end
			REQ_REDO: begin
				if (cursor_q < count_q) begin
					ex_read  = 1'b1;
					ex_pact  = ACT_APPLY;
					ex_pcur  = cur_up;
				end
			end
			REQ_SEEK: begin
				if (tgt_x > cnt_x) begin
					ex_res = mk(ACT_NONE, '0, 1'b1, STS_RANGE, '0,
						count_q, cursor_q, cpos_q, cvalid_q);
				end else if (cur_x < tgt_x) begin
					ex_read  = 1'b1;
					ex_pact  = ACT_APPLY;
					ex_pcur  = cur_up;
					ex_plast = (XW'(cur_up) == tgt_x);
				end else if (cur_x > tgt_x) begin
					ex_read  = 1'b1;
					ex_raddr = slot_dn;
					ex_pact  = ACT_REVERT;
					ex_ppos  = cur_dn[AW-1:0];
					ex_pcur  = cur_dn;
					ex_plast = (XW'(cur_dn) == tgt_x);
				end
			end
			REQ_CLEAR: begin
				ex_res = mk(ACT_NONE, '0, 1'b1, STS_OK, '0, '0, '0, '0, 1'b1);
			end
			REQ_MARK: begin
				ex_res = mk(ACT_NONE, '0, 1'b1, STS_OK, '0,
					count_q, cursor_q, cursor_q, 1'b1);
			end
			REQ_READ: begin
				if (tgt_x >= cnt_x) begin
					ex_res = mk(ACT_NONE, '0, 1'b1, STS_RANGE, '0,
						count_q, cursor_q, cpos_q, cvalid_q);
				end else begin
					ex_read  = 1'b1;
					ex_raddr = slot_tgt;
					ex_ppos  = tgt_x[AW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = out_valid_q;
	assign res       = out_q;
	assign ram_we    = (state_q == ST_EXEC) && !ex_read && ex_push && out_free;
	assign ram_waddr = p_wslot;
	assign ram_wdata = hnd_q;
	assign ram_re    = (state_q == ST_EXEC) && ex_read;
	assign ram_raddr = ex_raddr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			req_q       <= '0;
			hnd_q       <= '0;
			tgt_q       <= '0;
			base_q      <= '0;
			count_q     <= '0;
			cursor_q    <= '0;
			cpos_q      <= '0;
			cvalid_q    <= 1'b1;
			pend_act_q  <= ACT_NONE;
			pend_pos_q  <= '0;
			pend_cur_q  <= '0;
			pend_last_q <= 1'b0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && res_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						req_q   <= req_type;
						hnd_q   <= in_hw[HANDLE_BITS-1:0];
						tgt_q   <= target_index;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (ex_read) begin
						pend_act_q  <= ex_pact;
						pend_pos_q  <= ex_ppos;
						pend_cur_q  <= ex_pcur;
						pend_last_q <= ex_plast;
						state_q     <= ST_RDWAIT;
					end else if (out_free) begin
						out_q       <= ex_res;
						state_q     <= ST_IDLE;
						if (ex_push) begin
							base_q   <= p_base;
							count_q  <= p_count;
							cursor_q <= p_count;
							cpos_q   <= p_cp;
							cvalid_q <= p_cv;
						end
						if (req_q == REQ_CLEAR) begin
							base_q   <= '0;
							count_q  <= '0;
							cursor_q <= '0;
							cpos_q   <= '0;
							cvalid_q <= 1'b1;
						end
						if (req_q == REQ_MARK) begin
							cpos_q   <= cursor_q;
							cvalid_q <= 1'b1;
						end
					end
				end
				ST_RDWAIT: begin
					if (out_free) begin
						out_q <= mk(pend_act_q, pend_pos_q, pend_last_q, STS_OK, ram_rdata,
							count_q, pend_cur_q, cpos_q, cvalid_q);
						cursor_q    <= pend_cur_q;
						// A seek goes back for its next step until the last one.
						state_q     <= pend_last_q ? ST_IDLE : ST_EXEC;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/undo_redo_history_stack_unit.sv
// Undo/redo history stack top level: limit register, ring RAM and sequencer.
// Depends on urh_pkg, urh_ram and urh_ctrl.
//
// Usage: requests arrive on the in_valid/in_ready channel (req_type,
// command_handle, target_index). Each request produces one or more result
// beats on the out_valid/out_ready channel; the final beat of a request has
// last set. The undo_limit register is written through cfg_valid/cfg_ready,
// which is always ready; write it only while no request is in flight.
// Push, clear, mark clean and every rejected request give their beat from the
// execute state after acceptance. Undo, redo and read entry read the ring RAM
// first and give the beat from the read-wait state. A seek repeats this for
// each step, since each step is one RAM read followed by the beat.
// The sequencer handles one request at a time; the next request is accepted
// once the previous one has placed its last beat in the output register, so
// a waiting beat does not block acceptance. When the receiver stalls, the
// beat holds in the output register and the sequencer waits before the next.
// Reset clears the history (count, cursor 0, clean mark valid at 0) and the
// limit to 0 (meaning DEPTH); the RAM contents are not cleared.
module undo_redo_history_stack_unit
	import urh_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int HANDLE_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [REQ_W-1:0]        req_type,
	input  logic [31:0]             command_handle,
	input  logic [TGT_W-1:0]        target_index,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [LIM_W-1:0]        undo_limit,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [1:0]              action,
	output logic [OUT_HANDLE_W-1:0] handle_out,
	output logic [OUT_POS_W-1:0]    entry_pos,
	output logic                    last,
	output logic [1:0]              status,
	output logic                    can_undo,
	output logic                    can_redo,
	output logic [OUT_CNT_W-1:0]    entry_count,
	output logic [OUT_CNT_W-1:0]    cursor_pos,
	output logic                    is_clean
);

	localparam int AW = $clog2(DEPTH);

	logic [LIM_W-1:0]       undo_limit_q;
	res_t                   res;
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [HANDLE_BITS-1:0] ram_wdata;
	logic                   ram_re;
	logic [AW-1:0]          ram_raddr;
	logic [HANDLE_BITS-1:0] ram_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			undo_limit_q <= '0;
		end else if (cfg_valid) begin
			undo_limit_q <= undo_limit;
		end
	end

	urh_ram #(
		.DEPTH(DEPTH),
		.WIDTH(HANDLE_BITS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	urh_ctrl #(
		.DEPTH      (DEPTH),
		.HANDLE_BITS(HANDLE_BITS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.command_handle(command_handle),
		.target_index  (target_index),
		.limit         (undo_limit_q),
		.res_valid     (out_valid),
		.res_ready     (out_ready),
		.res           (res),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.ram_re        (ram_re),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata)
	);

	assign action      = res.action;
	assign handle_out  = res.handle;
	assign entry_pos   = res.pos;
	assign last        = res.last;
	assign status      = res.status;
	assign can_undo    = res.can_undo;
	assign can_redo    = res.can_redo;
	assign entry_count = res.count;
	assign cursor_pos  = res.cursor;
	assign is_clean    = res.is_clean;

endmodule
